// ===== hw/rtl/gbsa_pkg.sv =====
package gbsa_pkg;

    localparam int ACC_W          = 48;
    localparam int ENTRY_W        = ACC_W + 1;
    localparam int WEIGHT_IN_W    = 32;
    localparam int WEIGHT_PORTS   = 4;
    localparam int CODES_PER_BYTE = 4;
    localparam int HDR_BYTES      = 3;
    localparam int COUNT_W        = 13;

    localparam logic signed [ACC_W-1:0] ACC_MAX = {1'b0, {(ACC_W-1){1'b1}}};
    localparam logic signed [ACC_W-1:0] ACC_MIN = {1'b1, {(ACC_W-1){1'b0}}};

    typedef enum logic [1:0] {
        ACT_GENO  = 2'd0,
        ACT_READ  = 2'd1,
        ACT_CLEAR = 2'd2,
        ACT_NONE  = 2'd3
    } t_action;

    typedef enum logic [1:0] {
        DOS_ZERO = 2'd0,
        DOS_ONE  = 2'd1,
        DOS_TWO  = 2'd2
    } t_dosage;

    typedef enum logic {
        S_IDLE = 1'b0,
        S_RUN  = 1'b1
    } t_state;

    // control of the write stage of every lane
    typedef struct packed {
        logic    valid;
        t_dosage dosage;
        logic    fresh;
    } t_rmw_ctl;

    // control of the read result stage
    typedef struct packed {
        logic valid;
        logic ok;
    } t_rd_ctl;

    function automatic t_dosage dosage_of(input logic [1:0] code);
        t_dosage d;
        case (code)
            2'b11:   d = DOS_TWO;
            2'b10:   d = DOS_ONE;
            default: d = DOS_ZERO;
        endcase
        return d;
    endfunction

endpackage

// ===== hw/rtl/gbsa_in_if.sv =====
interface gbsa_in_if;
    logic               valid;
    logic               ready;
    logic [1:0]         action;
    logic [7:0]         data_byte;
    logic signed [31:0] weight_a;
    logic signed [31:0] weight_b;
    logic signed [31:0] weight_c;
    logic signed [31:0] weight_d;
    logic [11:0]        read_sample;
    logic [1:0]         read_score;

    modport source (
        output valid, action, data_byte, weight_a, weight_b, weight_c, weight_d,
               read_sample, read_score,
        input  ready
    );

    modport sink (
        input  valid, action, data_byte, weight_a, weight_b, weight_c, weight_d,
               read_sample, read_score,
        output ready
    );
endinterface

// ===== hw/rtl/gbsa_out_if.sv =====
interface gbsa_out_if;
    logic               valid;
    logic               ready;
    logic signed [47:0] score_value;
    logic               score_saturated;

    modport source (
        output valid, score_value, score_saturated,
        input  ready
    );

    modport sink (
        input  valid, score_value, score_saturated,
        output ready
    );
endinterface

// ===== hw/rtl/gbsa_lane.sv =====
module gbsa_lane
    import gbsa_pkg::*;
#(
    parameter int MAX_SAMPLES = 4096,
    parameter int WEIGHT_BITS = 32,
    localparam int AW = $clog2(MAX_SAMPLES)
) (
    input  logic                   i_clk,
    input  logic                   i_rd_en,
    input  logic [AW-1:0]          i_rd_addr,
    input  t_rmw_ctl               i_wr_ctl,
    input  logic [AW-1:0]          i_wr_addr,
    input  logic [WEIGHT_IN_W-1:0] i_weight,
    output logic [ENTRY_W-1:0]     o_rd_entry
);

    logic [ENTRY_W-1:0] r_mem [MAX_SAMPLES];
    logic [ENTRY_W-1:0] r_rdata;

    logic signed [WEIGHT_BITS-1:0] w_low;
    logic signed [ACC_W-1:0]       w_ext;
    logic signed [ACC_W-1:0]       addend;
    logic signed [ACC_W-1:0]       old_val;
    logic                          old_mark;
    logic signed [ACC_W:0]         sum;
    logic                          clip;
    logic signed [ACC_W-1:0]       new_val;
    logic [ENTRY_W-1:0]            wr_entry;

    always_comb begin
        w_low = i_weight[WEIGHT_BITS-1:0];
        w_ext = ACC_W'(w_low);
        case (i_wr_ctl.dosage)
            DOS_ONE: addend = w_ext;
            DOS_TWO: addend = w_ext <<< 1;
            default: addend = '0;
        endcase
        // an entry at or above the fill mark has not been written since the last clear
        old_val  = i_wr_ctl.fresh ? r_rdata[ACC_W-1:0] : '0;
        old_mark = i_wr_ctl.fresh ? r_rdata[ACC_W] : 1'b0;
        sum      = {old_val[ACC_W-1], old_val} + {addend[ACC_W-1], addend};
        clip     = sum[ACC_W] != sum[ACC_W-1];
        if (clip) begin
            new_val = sum[ACC_W] ? ACC_MIN : ACC_MAX;
        end else begin
            new_val = sum[ACC_W-1:0];
        end
        wr_entry = {old_mark | clip, new_val};
    end

    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rdata <= r_mem[i_rd_addr];
        end
        if (i_wr_ctl.valid) begin
            r_mem[i_wr_addr] <= wr_entry;
        end
    end

    assign o_rd_entry = r_rdata;

endmodule

// ===== hw/rtl/gbsa_merge.sv =====
module gbsa_merge
    import gbsa_pkg::*;
#(
    parameter int SCORE_COUNT = 4,
    localparam int SW = (SCORE_COUNT > 1) ? $clog2(SCORE_COUNT) : 1
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic [ENTRY_W-1:0] i_lane_entry [SCORE_COUNT],
    input  t_rd_ctl            i_rd,
    input  logic [SW-1:0]      i_rd_score,
    gbsa_out_if.source         o_score,
    output logic               o_skid_full
);

    logic [ENTRY_W-1:0] res;
    logic [ENTRY_W-1:0] r_out;
    logic [ENTRY_W-1:0] r_skid;
    logic               r_out_valid;
    logic               r_skid_valid;

    assign res = i_rd.ok ? i_lane_entry[i_rd_score] : '0;

    // output register with one skid entry behind it
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else begin
            if (!r_out_valid || o_score.ready) begin
                if (r_skid_valid) begin
                    r_out        <= r_skid;
                    r_skid_valid <= 1'b0;
                end else if (i_rd.valid) begin
                    r_out       <= res;
                    r_out_valid <= 1'b1;
                end else begin
                    r_out_valid <= 1'b0;
                end
            end else if (i_rd.valid) begin
                r_skid       <= res;
                r_skid_valid <= 1'b1;
            end
        end
    end

    assign o_score.valid           = r_out_valid;
    assign o_score.score_value     = r_out[ACC_W-1:0];
    assign o_score.score_saturated = r_out[ACC_W];
    assign o_skid_full             = r_skid_valid;

endmodule

// ===== hw/rtl/genotype_byte_score_accumulator_unit.sv =====
// Genotype byte score accumulator. Each beat on i_geno carries an action:
// a genotype byte, a read of one accumulator, or a clear. After reset or a
// clear the first three genotype bytes are header and are skipped. Every
// later byte holds four 2-bit codes, lowest pair first (00 and 01 give
// dosage 0, 10 gives 1, 11 gives 2); for each sample in turn the dosage
// times the byte's weights is added into that sample's scores, one lane
// and one score memory per score, with 48-bit saturation and a sticky clip
// mark. The sample position wraps to 0 as soon as it reaches sample_count,
// and the rest of that byte is dropped. Weights use their low WEIGHT_BITS
// bits, sign-extended; scores above the fourth get weight 0. Header bytes,
// clears and ignored actions leave the input ready for the next beat. A
// genotype byte on n samples (1 to 4) issues the first from the accepted
// beat, the rest from the run state, as each lane's score memory does one
// read-modify-write a cycle; the write stage drains before the next beat.
// A read result is registered in the lanes, then in the output register,
// where one beat may wait, with one more in a skid entry. A clear does not
// walk the store: a fill count marks how far it is written since the clear,
// and entries at or above it read as zero with no clip mark.
// sample_count is written through i_cfg_we/i_cfg_data while the block is
// idle; 0 acts as 1 and values above MAX_SAMPLES act as MAX_SAMPLES.
module genotype_byte_score_accumulator_unit
    import gbsa_pkg::*;
#(
    parameter int MAX_SAMPLES = 4096,
    parameter int SCORE_COUNT = 4,
    parameter int WEIGHT_BITS = 32
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    gbsa_in_if.sink            i_geno,
    gbsa_out_if.source         o_score,
    input  logic               i_cfg_we,
    input  logic [COUNT_W-1:0] i_cfg_data
);

    localparam int AW = $clog2(MAX_SAMPLES);
    localparam int FW = $clog2(MAX_SAMPLES + 1);
    localparam int SW = (SCORE_COUNT > 1) ? $clog2(SCORE_COUNT) : 1;
    localparam logic [1:0] HDR_DONE  = 2'(HDR_BYTES);
    localparam logic [1:0] LAST_CODE = 2'(CODES_PER_BYTE - 1);

    t_state                 r_state;
    t_state                 n_state;
    logic [COUNT_W-1:0]     r_count;
    logic [1:0]             r_hdr;
    logic [AW-1:0]          r_pos;
    logic [FW-1:0]          r_fill;
    logic [1:0]             r_k;
    logic [7:0]             r_byte;
    logic [WEIGHT_IN_W-1:0] r_w [WEIGHT_PORTS];
    t_rmw_ctl               r_s2;
    logic [AW-1:0]          r_s2_addr;
    t_rd_ctl                r_rd;
    logic [SW-1:0]          r_rd_score;

    logic                   accept;
    logic                   is_geno;
    logic                   is_read;
    logic                   is_clear;
    logic                   hdr_done;
    logic [FW-1:0]          limit;
    logic [FW-1:0]          pos_inc;
    logic                   wrap;
    logic                   iss_valid;
    logic [1:0]             iss_code;
    logic                   rd_ok;
    logic                   skid_full;
    logic [AW-1:0]          rd_addr;
    logic [AW-1:0]          lane_addr;
    logic                   lane_rd_en;
    logic [WEIGHT_IN_W-1:0] lane_w [SCORE_COUNT];
    logic [ENTRY_W-1:0]     lane_entry [SCORE_COUNT];

    assign accept   = i_geno.valid & i_geno.ready;
    assign is_geno  = i_geno.action == ACT_GENO;
    assign is_read  = i_geno.action == ACT_READ;
    assign is_clear = i_geno.action == ACT_CLEAR;
    assign hdr_done = r_hdr == HDR_DONE;

    // effective sample count
    always_comb begin
        if (r_count == '0) begin
            limit = FW'(1);
        end else if (32'(r_count) > MAX_SAMPLES) begin
            limit = FW'(MAX_SAMPLES);
        end else begin
            limit = FW'(r_count);
        end
    end

    assign pos_inc = FW'(r_pos) + FW'(1);
    assign wrap    = pos_inc >= limit;

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (accept && is_geno && hdr_done && !wrap) begin
                    n_state = S_RUN;
                end
            end
            S_RUN: begin
                if (wrap || r_k == LAST_CODE) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // sequencer outputs: the first sample issues straight from the accepted beat
    always_comb begin
        i_geno.ready = 1'b0;
        iss_valid    = 1'b0;
        iss_code     = i_geno.data_byte[1:0];
        case (r_state)
            S_IDLE: begin
                i_geno.ready = !r_s2.valid && !r_rd.valid && !skid_full;
                iss_valid    = accept && is_geno && hdr_done;
            end
            S_RUN: begin
                iss_valid = 1'b1;
                iss_code  = r_byte[{r_k, 1'b0} +: 2];
            end
            default: begin
                i_geno.ready = 1'b0;
            end
        endcase
    end

    assign rd_ok = (32'(i_geno.read_sample) < MAX_SAMPLES)
                && (32'(i_geno.read_score) < SCORE_COUNT)
                && (32'(i_geno.read_sample) < 32'(r_fill));
    assign rd_addr    = AW'(32'(i_geno.read_sample));
    assign lane_rd_en = iss_valid || (accept && is_read);
    assign lane_addr  = iss_valid ? r_pos : rd_addr;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_count <= COUNT_W'(1);
            r_hdr   <= '0;
            r_pos   <= '0;
            r_fill  <= '0;
            r_k     <= '0;
            r_s2    <= '0;
            r_rd    <= '0;
        end else begin
            r_state <= n_state;
            if (i_cfg_we) begin
                r_count <= i_cfg_data;
            end
            if (accept && is_geno) begin
                r_byte <= i_geno.data_byte;
                r_w[0] <= i_geno.weight_a;
                r_w[1] <= i_geno.weight_b;
                r_w[2] <= i_geno.weight_c;
                r_w[3] <= i_geno.weight_d;
                r_k    <= 2'd1;
                if (!hdr_done) begin
                    r_hdr <= r_hdr + 2'd1;
                end
            end else if (r_state == S_RUN) begin
                r_k <= r_k + 2'd1;
            end
            // advance the sample position, wrap at the count
            if (iss_valid) begin
                r_pos <= wrap ? '0 : AW'(pos_inc);
                if (pos_inc > r_fill) begin
                    r_fill <= pos_inc;
                end
            end
            if (accept && is_clear) begin
                r_hdr  <= '0;
                r_pos  <= '0;
                r_fill <= '0;
            end
            r_s2.valid  <= iss_valid;
            r_s2.dosage <= dosage_of(iss_code);
            r_s2.fresh  <= FW'(r_pos) < r_fill;
            r_rd.valid  <= accept && is_read;
            r_rd.ok     <= rd_ok;
        end
    end

    always_ff @(posedge i_clk) begin
        r_s2_addr  <= r_pos;
        r_rd_score <= SW'(32'(i_geno.read_score));
    end

    for (genvar s = 0; s < SCORE_COUNT; s++) begin : g_lane
        if (s < WEIGHT_PORTS) begin : g_w
            assign lane_w[s] = r_w[s];
        end else begin : g_zero
            assign lane_w[s] = '0;
        end

        gbsa_lane #(
            .MAX_SAMPLES (MAX_SAMPLES),
            .WEIGHT_BITS (WEIGHT_BITS)
        ) u_lane (
            .i_clk      (i_clk),
            .i_rd_en    (lane_rd_en),
            .i_rd_addr  (lane_addr),
            .i_wr_ctl   (r_s2),
            .i_wr_addr  (r_s2_addr),
            .i_weight   (lane_w[s]),
            .o_rd_entry (lane_entry[s])
        );
    end

    gbsa_merge #(
        .SCORE_COUNT (SCORE_COUNT)
    ) u_merge (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_lane_entry (lane_entry),
        .i_rd         (r_rd),
        .i_rd_score   (r_rd_score),
        .o_score      (o_score),
        .o_skid_full  (skid_full)
    );

endmodule

// ===== hw/rtl/gbsa_checker.sv =====
module gbsa_checker
    import gbsa_pkg::*;
(
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       i_in_valid,
    input logic       i_in_ready,
    input logic [1:0] i_in_action,
    input logic       i_out_valid,
    input logic       i_out_ready
);

    logic in_beat;
    assign in_beat = i_in_valid && i_in_ready;

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid)
        else $error("result beat dropped while stalled");

    a_reset_quiet: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("result valid after reset");

    a_result_from_read: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(i_out_valid) |-> $past(in_beat && i_in_action == ACT_READ, 2))
        else $error("result beat without a read two cycles before");

    a_read_stalls: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_beat && i_in_action == ACT_READ |=> !i_in_ready)
        else $error("input ready while a read is in flight");

    a_clear_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_beat && i_in_action == ACT_CLEAR |=> i_in_ready)
        else $error("input not ready after a clear");

endmodule

bind genotype_byte_score_accumulator_unit gbsa_checker u_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_geno.valid),
    .i_in_ready  (i_geno.ready),
    .i_in_action (i_geno.action),
    .i_out_valid (o_score.valid),
    .i_out_ready (o_score.ready)
);

// ===== test/tb_genotype_byte_score_accumulator_unit.sv =====
module tb_genotype_byte_score_accumulator_unit;
    import gbsa_pkg::*;

    localparam int MAX_SAMPLES    = 4096;
    localparam int SCORES         = 4;
    localparam int WATCHDOG_LIMIT = 4000;
    // margin to let the last genotype byte finish before a count write
    localparam int DRAIN_CYCLES   = 8;
    localparam int TAIL_CYCLES    = 20;
    localparam int LONG_HOLD      = 300;
    // full-scale bytes on sample 0 with a sample count of 1: each adds 2 * weight,
    // driving the scores far from zero in both directions
    localparam int HEAVY_BYTES    = 24;

    typedef struct {
        t_action            act;
        logic [7:0]         data;
        logic signed [31:0] wa;
        logic signed [31:0] wb;
        logic signed [31:0] wc;
        logic signed [31:0] wd;
        logic [11:0]        smp;
        logic [1:0]         sc;
    } t_geno_beat;

    typedef struct {
        logic signed [ACC_W-1:0] value;
        logic                    sat;
    } t_score_beat;

    typedef struct {
        bit                 is_cfg;
        logic [COUNT_W-1:0] count;
        t_geno_beat         beat;
        bit                 typed;
        t_score_beat        want;
    } t_plan_row;

    logic               i_clk;
    logic               i_rst_n;
    logic               i_cfg_we;
    logic [COUNT_W-1:0] i_cfg_data;

    gbsa_in_if  geno_if ();
    gbsa_out_if score_if ();

    genotype_byte_score_accumulator_unit DUT (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_geno     (geno_if),
        .o_score    (score_if),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_data (i_cfg_data)
    );

    // score predictor: its own copy of the store, the clip marks and the stream position
    logic signed [ACC_W-1:0] acc_store [MAX_SAMPLES*SCORES];
    bit                      clip_store [MAX_SAMPLES*SCORES];
    int unsigned             hdr_seen;
    int unsigned             sample_pos;
    logic [COUNT_W-1:0]      count_reg;

    t_score_beat pending_scores [$];
    t_plan_row   plan [$];
    t_score_beat no_score;

    int errors     = 0;
    int beats_in   = 0;
    int beats_out  = 0;
    int clip_reads = 0;

    // steady: neither side idles; burst: the sender offers back to back
    bit steady        = 1'b0;
    bit burst         = 1'b0;
    bit long_hold_req = 1'b0;

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    function automatic void clear_scores();
        foreach (acc_store[i]) begin
            acc_store[i]  = '0;
            clip_store[i] = 1'b0;
        end
        hdr_seen   = 0;
        sample_pos = 0;
    endfunction

    // 0 acts as 1, anything past the store acts as the store size
    function automatic int unsigned live_count();
        if (count_reg == 0) return 1;
        if (count_reg > MAX_SAMPLES) return MAX_SAMPLES;
        return count_reg;
    endfunction

    function automatic void add_score(input int unsigned idx, input longint delta);
        longint cur;
        longint hi;
        longint lo;
        longint sum;
        cur = acc_store[idx];
        hi  = ACC_MAX;
        lo  = ACC_MIN;
        sum = cur + delta;
        // clip at the 48-bit limits and mark the entry until the next clear
        if (sum > hi) begin
            sum = hi;
            clip_store[idx] = 1'b1;
        end else if (sum < lo) begin
            sum = lo;
            clip_store[idx] = 1'b1;
        end
        acc_store[idx] = sum[ACC_W-1:0];
    endfunction

    // advance the predictor by one accepted beat; return 1 where a score beat follows
    function automatic bit predict_score(input t_geno_beat b, output t_score_beat r);
        longint      w [SCORES];
        longint      dose;
        int unsigned limit;
        int unsigned pos;
        int unsigned idx;
        int          k;
        int          s;
        logic [1:0]  code;
        r.value = '0;
        r.sat   = 1'b0;
        case (b.act)
            ACT_GENO: begin
                if (hdr_seen < HDR_BYTES) begin
                    hdr_seen++;
                    return 1'b0;
                end
                w[0] = b.wa;
                w[1] = b.wb;
                w[2] = b.wc;
                w[3] = b.wd;
                limit = live_count();
                for (k = 0; k < CODES_PER_BYTE; k++) begin
                    // lowest pair first; low-bit-only is a missing call and adds nothing
                    code = b.data[2*k +: 2];
                    dose = (code == 2'b11) ? 2 : ((code == 2'b10) ? 1 : 0);
                    pos  = (sample_pos >= MAX_SAMPLES) ? 0 : sample_pos;
                    for (s = 0; s < SCORES; s++)
                        add_score(pos * SCORES + s, dose * w[s]);
                    pos++;
                    // wrap at once and drop the padding left in this byte
                    if (pos >= limit) begin
                        sample_pos = 0;
                        break;
                    end
                    sample_pos = pos;
                end
                return 1'b0;
            end
            ACT_READ: begin
                idx     = b.smp * SCORES + b.sc;
                r.value = acc_store[idx];
                r.sat   = clip_store[idx];
                return 1'b1;
            end
            ACT_CLEAR: begin
                clear_scores();
                return 1'b0;
            end
            default: return 1'b0;
        endcase
    endfunction

    function automatic logic signed [31:0] rand_weight();
        case ($urandom_range(0, 5))
            0:       return 32'sh7FFF_FFFF;
            1:       return 32'sh8000_0000;
            2:       return 32'($urandom_range(0, 32'h0200_0000)) - 32'h0100_0000;
            default: return $urandom();
        endcase
    endfunction

    function automatic t_geno_beat noise_beat();
        t_geno_beat b;
        b.act  = t_action'($urandom_range(0, 3));
        b.data = 8'($urandom_range(0, 255));
        b.wa   = rand_weight();
        b.wb   = rand_weight();
        b.wc   = rand_weight();
        b.wd   = rand_weight();
        b.smp  = 12'($urandom_range(0, MAX_SAMPLES - 1));
        b.sc   = 2'($urandom_range(0, SCORES - 1));
        return b;
    endfunction

    function automatic void plan_beat(input t_action act, input logic [7:0] data,
                                      input logic signed [31:0] wa, input logic signed [31:0] wb,
                                      input logic signed [31:0] wc, input logic signed [31:0] wd,
                                      input logic [11:0] smp, input logic [1:0] sc);
        t_plan_row row;
        row.is_cfg    = 1'b0;
        row.count     = '0;
        row.beat.act  = act;
        row.beat.data = data;
        row.beat.wa   = wa;
        row.beat.wb   = wb;
        row.beat.wc   = wc;
        row.beat.wd   = wd;
        row.beat.smp  = smp;
        row.beat.sc   = sc;
        row.typed     = 1'b0;
        row.want      = no_score;
        plan.push_back(row);
    endfunction

    // a read whose answer is obvious: typed in rather than taken from the predictor
    function automatic void plan_read_typed(input logic [11:0] smp, input logic [1:0] sc,
                                            input logic signed [ACC_W-1:0] value,
                                            input logic sat);
        plan_beat(ACT_READ, 8'h00, 0, 0, 0, 0, smp, sc);
        plan[$].typed      = 1'b1;
        plan[$].want.value = value;
        plan[$].want.sat   = sat;
    endfunction

    function automatic void plan_count(input logic [COUNT_W-1:0] v);
        plan_beat(ACT_NONE, 8'h00, 0, 0, 0, 0, 12'd0, 2'd0);
        plan[$].is_cfg = 1'b1;
        plan[$].count  = v;
    endfunction

    function automatic int pick_gap();
        int r;
        if (burst || steady) return 0;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 90) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // offer one beat, hold it until accepted, then advance the predictor
    task automatic put_beat(input t_geno_beat b, input bit typed, input t_score_beat want);
        int          gap;
        t_score_beat got;
        gap = pick_gap();
        if (gap > 0) begin
            geno_if.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        geno_if.valid       <= 1'b1;
        geno_if.action      <= b.act;
        geno_if.data_byte   <= b.data;
        geno_if.weight_a    <= b.wa;
        geno_if.weight_b    <= b.wb;
        geno_if.weight_c    <= b.wc;
        geno_if.weight_d    <= b.wd;
        geno_if.read_sample <= b.smp;
        geno_if.read_score  <= b.sc;
        do @(posedge i_clk); while (!geno_if.ready);
        beats_in++;
        if (predict_score(b, got))
            pending_scores.push_back(typed ? want : got);
    endtask

    // drop valid, wait out every expected score beat and let the last byte finish
    task automatic wait_drained();
        geno_if.valid <= 1'b0;
        while (pending_scores.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_count(input logic [COUNT_W-1:0] v);
        wait_drained();
        i_cfg_we   <= 1'b1;
        i_cfg_data <= v;
        @(posedge i_clk);
        i_cfg_we   <= 1'b0;
        count_reg = v;
    endtask

    // clear, then three header bytes of random content
    task automatic start_stream();
        t_geno_beat b;
        int         i;
        b = noise_beat();
        b.act = ACT_CLEAR;
        put_beat(b, 1'b0, no_score);
        for (i = 0; i < HDR_BYTES; i++) begin
            b = noise_beat();
            b.act = ACT_GENO;
            put_beat(b, 1'b0, no_score);
        end
    endtask

    // one random phase: well-formed variants with random content, reads of the
    // touched samples, and some noise, restarts and pauses
    task automatic run_phase(input logic [COUNT_W-1:0] count, input int items,
                             input bit quiet, input bit with_hold);
        t_geno_beat  b;
        t_geno_beat  variant;
        int unsigned span;
        int          variant_left;
        int          n;
        int          i;
        int          r;
        write_count(count);
        steady = quiet;
        span   = (live_count() < 48) ? live_count() : 48;
        start_stream();
        variant_left = 0;
        variant      = noise_beat();
        for (n = 0; n < items; n++) begin
            if (with_hold && n == items / 2) begin
                // hold the score side off and offer twelve reads back to back, so the input stalls
                long_hold_req = 1'b1;
                burst = 1'b1;
                for (i = 0; i < 12; i++) begin
                    b = noise_beat();
                    b.act = ACT_READ;
                    b.smp = 12'($urandom_range(0, span - 1));
                    put_beat(b, 1'b0, no_score);
                end
                burst = 1'b0;
            end
            r = $urandom_range(0, 99);
            b = noise_beat();
            if (r < 55) begin
                // the weights stay fixed over the bytes of one variant
                if (variant_left == 0) begin
                    variant = noise_beat();
                    variant_left = (live_count() + 3) / 4;
                    if (variant_left > 16) variant_left = 16;
                end
                variant_left--;
                b.act = ACT_GENO;
                b.wa  = variant.wa;
                b.wb  = variant.wb;
                b.wc  = variant.wc;
                b.wd  = variant.wd;
            end else if (r < 85) begin
                b.act = ACT_READ;
                if ($urandom_range(0, 3) != 0) b.smp = 12'($urandom_range(0, span - 1));
            end else if (r < 88) begin
                b.act = ACT_NONE;
            end else if (r < 91) begin
                start_stream();
                variant_left = 0;
                continue;
            end else if (r < 93) begin
                wait_drained();
                continue;
            end
            put_beat(b, 1'b0, no_score);
        end
        steady = 1'b0;
    endtask

    task automatic check_score();
        t_score_beat want;
        beats_out++;
        if (score_if.score_saturated === 1'b1) clip_reads++;
        if (pending_scores.size() == 0) begin
            errors++;
            $display("%0t: score beat with nothing expected: value %h clip %b", $time,
                     score_if.score_value, score_if.score_saturated);
            return;
        end
        want = pending_scores.pop_front();
        if (score_if.score_value !== want.value) begin
            errors++;
            $display("%0t: score_value expected %h actual %h", $time,
                     want.value, score_if.score_value);
        end
        if (score_if.score_saturated !== want.sat) begin
            errors++;
            $display("%0t: score_saturated expected %b actual %b", $time,
                     want.sat, score_if.score_saturated);
        end
    endtask

    // score side: check each beat taken, stall at random, honour a long hold-off
    initial begin : score_sink
        int stall_left;
        stall_left = 0;
        score_if.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (score_if.valid && score_if.ready) check_score();
            if (long_hold_req) begin
                stall_left    = LONG_HOLD;
                long_hold_req = 1'b0;
            end
            if (stall_left > 0) begin
                score_if.ready <= 1'b0;
                stall_left--;
            end else if (steady || $urandom_range(0, 99) < 70) begin
                score_if.ready <= 1'b1;
            end else begin
                score_if.ready <= 1'b0;
                stall_left = ($urandom_range(0, 99) < 85) ? $urandom_range(0, 2)
                                                           : $urandom_range(8, 40);
            end
        end
    end

    // end the run if no beat and no register write happens for too long
    initial begin : watchdog
        int quiet_cycles;
        quiet_cycles = 0;
        while (quiet_cycles < WATCHDOG_LIMIT) begin
            @(posedge i_clk);
            if ((geno_if.valid && geno_if.ready) || (score_if.valid && score_if.ready)
                || i_cfg_we)
                quiet_cycles = 0;
            else
                quiet_cycles++;
        end
        $display("%0t: no beat for %0d cycles, %0d score beats still expected", $time,
                 WATCHDOG_LIMIT, pending_scores.size());
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    initial begin : stimulus
        t_plan_row  row;
        t_geno_beat b;
        int         i;

        geno_if.valid       <= 1'b0;
        geno_if.action      <= ACT_NONE;
        geno_if.data_byte   <= '0;
        geno_if.weight_a    <= '0;
        geno_if.weight_b    <= '0;
        geno_if.weight_c    <= '0;
        geno_if.weight_d    <= '0;
        geno_if.read_sample <= '0;
        geno_if.read_score  <= '0;
        i_cfg_we            <= 1'b0;
        i_cfg_data          <= '0;
        i_rst_n             <= 1'b0;
        no_score.value = '0;
        no_score.sat   = 1'b0;
        count_reg = COUNT_W'(1);
        clear_scores();
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed: empty store, headers around an ignored action, a mid-byte wrap,
        // a clear, then counts past the store and of zero
        plan_read_typed(12'd0, 2'd0, '0, 1'b0);
        plan_read_typed(12'd4095, 2'd3, '0, 1'b0);
        plan_beat(ACT_GENO, 8'hFF, 32'sh7FFF_FFFF, 32'sh8000_0000, 32'sh7FFF_FFFF,
                  32'sh8000_0000, 12'd0, 2'd0);
        plan_beat(ACT_NONE, 8'hAA, 1, 1, 1, 1, 12'd4095, 2'd3);
        plan_beat(ACT_GENO, 8'h00, 0, 0, 0, 0, 12'd0, 2'd0);
        plan_beat(ACT_GENO, 8'h55, -1, -1, -1, -1, 12'd0, 2'd0);
        plan_count(13'd6);
        // codes 00, missing, 10, 11 on samples 0..3
        plan_beat(ACT_GENO, 8'hE4, 32'sh7FFF_FFFF, 32'sh8000_0000, 1, -1, 12'd0, 2'd0);
        // samples 4 and 5, then wrap and drop the last two codes
        plan_beat(ACT_GENO, 8'h1B, 32'sh7FFF_FFFF, 32'sh8000_0000, 1, -1, 12'd0, 2'd0);
        plan_beat(ACT_GENO, 8'hFF, 32'sh0100_0000, 32'shFF00_0000, 0, 32'sh7FFF_FFFF,
                  12'd0, 2'd0);
        plan_beat(ACT_READ, 8'h00, 0, 0, 0, 0, 12'd2, 2'd0);
        plan_beat(ACT_READ, 8'h00, 0, 0, 0, 0, 12'd3, 2'd1);
        plan_beat(ACT_READ, 8'h00, 0, 0, 0, 0, 12'd4, 2'd2);
        plan_beat(ACT_READ, 8'h00, 0, 0, 0, 0, 12'd5, 2'd3);
        plan_beat(ACT_CLEAR, 8'h00, 0, 0, 0, 0, 12'd0, 2'd0);
        plan_read_typed(12'd3, 2'd0, '0, 1'b0);
        plan_count(13'd8191);
        for (i = 0; i < HDR_BYTES; i++)
            plan_beat(ACT_GENO, 8'hFF, 32'sh7FFF_FFFF, 0, 0, 0, 12'd0, 2'd0);
        plan_beat(ACT_GENO, 8'hFF, -1, -1, -1, -1, 12'd0, 2'd0);
        plan_beat(ACT_READ, 8'h00, 0, 0, 0, 0, 12'd1, 2'd3);
        // position is 4 when the count drops to 1: one more sample, then wrap
        plan_count(13'd0);
        plan_beat(ACT_GENO, 8'h0E, 32'sh0080_0000, 2, 3, 4, 12'd0, 2'd0);
        plan_beat(ACT_GENO, 8'h03, 32'sh0080_0000, 2, 3, 4, 12'd0, 2'd0);
        plan_beat(ACT_READ, 8'h00, 0, 0, 0, 0, 12'd4, 2'd0);
        plan_beat(ACT_READ, 8'h00, 0, 0, 0, 0, 12'd0, 2'd0);

        foreach (plan[i]) begin
            row = plan[i];
            if (row.is_cfg)
                write_count(row.count);
            else
                put_beat(row.beat, row.typed, row.want);
        end

        run_phase(13'd4, 50, 1'b0, 1'b0);
        run_phase(13'd7, 50, 1'b0, 1'b1);
        run_phase(13'd4096, 50, 1'b1, 1'b0);
        run_phase(13'd1, 50, 1'b0, 1'b0);
        run_phase(13'd13, 50, 1'b0, 1'b0);

        // drive sample 0 hard in both directions, then pull scores 0 and 1 back
        write_count(13'd1);
        steady = 1'b1;
        start_stream();
        b = noise_beat();
        b.act  = ACT_GENO;
        b.data = 8'hFF;
        b.wa   = 32'sh7FFF_FFFF;
        b.wb   = 32'sh8000_0000;
        b.wc   = 32'sh0040_0000;
        b.wd   = '0;
        repeat (HEAVY_BYTES) put_beat(b, 1'b0, no_score);
        for (i = 0; i < 2 * SCORES; i++) begin
            if (i == SCORES) begin
                b.act  = ACT_GENO;
                b.data = 8'h03;
                b.wa   = 32'sh8000_0000;
                b.wb   = 32'sh7FFF_FFFF;
                repeat (4) put_beat(b, 1'b0, no_score);
            end
            b.act = ACT_READ;
            b.smp = '0;
            b.sc  = 2'(i % SCORES);
            put_beat(b, 1'b0, no_score);
        end
        steady = 1'b0;

        run_phase(13'd2, 50, 1'b0, 1'b0);
        run_phase(COUNT_W'($urandom_range(3, 40)), 50, 1'b0, 1'b0);

        geno_if.valid <= 1'b0;
        while (pending_scores.size() != 0) @(posedge i_clk);
        repeat (TAIL_CYCLES) @(posedge i_clk);

        $display("Ran %0d input beats and checked %0d score beats, %0d with the clip mark set,",
                 beats_in, beats_out, clip_reads);
        $display("over sample counts 0 to 8191, clears, idle actions and full-scale weights");
        if (errors == 0 && pending_scores.size() == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule

// ===== sim.f =====
hw/rtl/gbsa_pkg.sv
hw/rtl/gbsa_in_if.sv
hw/rtl/gbsa_out_if.sv
hw/rtl/gbsa_lane.sv
hw/rtl/gbsa_merge.sv
hw/rtl/genotype_byte_score_accumulator_unit.sv
hw/rtl/gbsa_checker.sv
test/tb_genotype_byte_score_accumulator_unit.sv
